// ===== design/cptxz_pkg.sv =====
package cptxz_pkg;

  localparam int CW = 32;
  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;
  localparam int QW = DW + 1;
  localparam int NW = PW + QW;
  localparam int MW = 3 * DW;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);

  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_END   = 2'd1;
  localparam logic [1:0] MODE_MID   = 2'd2;

  localparam logic [1:0] REGION_INSIDE = 2'd0;
  localparam logic [1:0] REGION_AB     = 2'd1;
  localparam logic [1:0] REGION_BC     = 2'd2;
  localparam logic [1:0] REGION_CA     = 2'd3;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } vec_t;

  typedef struct packed {
    logic [1:0]           mode;
    logic signed [PW-1:0] dot;
    logic signed [PW-1:0] len2;
  } seg_t;

  typedef struct packed {
    vec_t                 p;
    vec_t                 a;
    vec_t                 b;
    vec_t                 c;
    logic                 interior;
    logic signed [PW-1:0] den;
    logic signed [PW-1:0] nv;
    logic signed [PW-1:0] nw;
    seg_t [2:0]           seg;
  } job_t;

endpackage

// ===== design/cptxz_wmul.sv =====
module cptxz_wmul (
  input  logic                           clk,
  input  logic signed [cptxz_pkg::PW-1:0] a,
  input  logic signed [cptxz_pkg::DW-1:0] b,
  output logic signed [cptxz_pkg::MW-1:0] p
);
  import cptxz_pkg::*;

  logic signed [DW:0]     lo_ext;
  logic signed [DW-1:0]   hi;
  logic signed [2*DW:0]   pl;
  logic signed [2*DW-1:0] ph;

  assign lo_ext = $signed({1'b0, a[DW-1:0]});
  assign hi     = $signed(a[PW-1:DW]);

  always_ff @(posedge clk) begin
    pl <= lo_ext * b;
    ph <= hi * b;
    p  <= (MW'(ph) <<< DW) + MW'(pl);
  end

endmodule

// ===== design/cptxz_div.sv =====
module cptxz_div (
  input  logic                        clk,
  input  logic [cptxz_pkg::NW-1:0]    x0,
  input  logic [cptxz_pkg::PW-1:0]    dvs,
  output logic [cptxz_pkg::QW-1:0]    quo
);
  import cptxz_pkg::*;

  logic [NW-1:0] xs [QW];
  logic [PW-1:0] ds [QW-1];

  function automatic logic [NW-1:0] step(logic [NW-1:0] x, logic [PW-1:0] d);
    logic [NW:0] sh;
    logic [PW:0] top;
    logic [PW:0] diff;
    sh   = {x, 1'b0};
    top  = sh[NW:QW];
    diff = top - {1'b0, d};
    if (top >= {1'b0, d}) begin
      return {diff[PW-1:0], sh[QW-1:1], 1'b1};
    end
    return sh[NW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    xs[0] <= step(x0, dvs);
    ds[0] <= dvs;
    for (int i = 1; i < QW; i++) begin
      xs[i] <= step(xs[i-1], ds[i-1]);
    end
    for (int i = 1; i < QW - 1; i++) begin
      ds[i] <= ds[i-1];
    end
  end

  assign quo = xs[QW-1][QW-1:0];

endmodule

// ===== design/cptxz_fifo.sv =====
module cptxz_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  cptxz_pkg::job_t wdata,
  input  logic            pop,
  output logic            valid,
  output cptxz_pkg::job_t rdata,
  output logic            full
);
  import cptxz_pkg::*;

  job_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr;
  logic [FIFO_AW-1:0] rptr;
  logic [FIFO_AW:0]   count;
  logic               do_pop;

  assign valid  = (count != '0);
  assign full   = (count == (FIFO_AW+1)'(FIFO_DEPTH));
  assign rdata  = mem[rptr];
  assign do_pop = pop && valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      unique case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/cptxz_front.sv =====
module cptxz_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  cptxz_pkg::vec_t p,
  input  cptxz_pkg::vec_t a,
  input  cptxz_pkg::vec_t b,
  input  cptxz_pkg::vec_t c,
  input  logic            full,
  output logic            busy,
  output logic            push,
  output cptxz_pkg::job_t job
);
  import cptxz_pkg::*;

  logic advance;
  logic v1, v2, v3;
  vec_t p1, a1, b1, c1;
  vec_t p2, a2, b2, c2;
  vec_t p3, a3, b3, c3;

  logic signed [DW-1:0] bax, baz, cax, caz, pax, paz;
  vec_t                 sv [3];
  vec_t                 ev [3];
  logic signed [DW-1:0] edx [3];
  logic signed [DW-1:0] edz [3];
  logic signed [DW-1:0] psx [3];
  logic signed [DW-1:0] psz [3];

  logic signed [PW-1:0] dn0, dn1, nv0, nv1, nw0, nw1;
  logic signed [PW-1:0] ln0 [3];
  logic signed [PW-1:0] ln1 [3];
  logic signed [PW-1:0] dt0 [3];
  logic signed [PW-1:0] dt1 [3];

  logic signed [PW-1:0] den3, nv3, nw3;
  logic signed [PW-1:0] len3 [3];
  logic signed [PW-1:0] dot3 [3];

  logic                 dneg;
  logic signed [PW-1:0] dabs, nvs, nws;
  logic signed [PW+1:0] nu;

  assign advance = !(v3 && full);
  assign busy    = !advance;
  assign push    = v3 && advance;

  always_comb begin
    bax = DW'($signed(b1.x)) - DW'($signed(a1.x));
    baz = DW'($signed(b1.z)) - DW'($signed(a1.z));
    cax = DW'($signed(c1.x)) - DW'($signed(a1.x));
    caz = DW'($signed(c1.z)) - DW'($signed(a1.z));
    pax = DW'($signed(p1.x)) - DW'($signed(a1.x));
    paz = DW'($signed(p1.z)) - DW'($signed(a1.z));
    sv[0] = a1;
    sv[1] = b1;
    sv[2] = c1;
    ev[0] = b1;
    ev[1] = c1;
    ev[2] = a1;
    for (int k = 0; k < 3; k++) begin
      edx[k] = DW'($signed(ev[k].x)) - DW'($signed(sv[k].x));
      edz[k] = DW'($signed(ev[k].z)) - DW'($signed(sv[k].z));
      psx[k] = DW'($signed(p1.x)) - DW'($signed(sv[k].x));
      psz[k] = DW'($signed(p1.z)) - DW'($signed(sv[k].z));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (advance) begin
      v1 <= start;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p1 <= p;
      a1 <= a;
      b1 <= b;
      c1 <= c;

      dn0 <= bax * caz;
      dn1 <= baz * cax;
      nv0 <= pax * caz;
      nv1 <= paz * cax;
      nw0 <= bax * paz;
      nw1 <= baz * pax;
      for (int k = 0; k < 3; k++) begin
        ln0[k] <= edx[k] * edx[k];
        ln1[k] <= edz[k] * edz[k];
        dt0[k] <= psx[k] * edx[k];
        dt1[k] <= psz[k] * edz[k];
      end
      p2 <= p1;
      a2 <= a1;
      b2 <= b1;
      c2 <= c1;

      den3 <= dn0 - dn1;
      nv3  <= nv0 - nv1;
      nw3  <= nw0 - nw1;
      for (int k = 0; k < 3; k++) begin
        len3[k] <= ln0[k] + ln1[k];
        dot3[k] <= dt0[k] + dt1[k];
      end
      p3 <= p2;
      a3 <= a2;
      b3 <= b2;
      c3 <= c2;
    end
  end

  always_comb begin
    dneg = den3[PW-1];
    dabs = dneg ? -den3 : den3;
    nvs  = dneg ? -nv3 : nv3;
    nws  = dneg ? -nw3 : nw3;
    nu   = (PW+2)'(dabs) - (PW+2)'(nvs) - (PW+2)'(nws);

    job.p        = p3;
    job.a        = a3;
    job.b        = b3;
    job.c        = c3;
    job.interior = (den3 != '0) && !nu[PW+1] && !nvs[PW-1] && !nws[PW-1];
    job.den      = dabs;
    job.nv       = nvs;
    job.nw       = nws;
    for (int k = 0; k < 3; k++) begin
      job.seg[k].dot  = dot3[k];
      job.seg[k].len2 = len3[k];
      if ((len3[k] == '0) || dot3[k][PW-1] || (dot3[k] == '0)) begin
        job.seg[k].mode = MODE_START;
      end else if (dot3[k] >= len3[k]) begin
        job.seg[k].mode = MODE_END;
      end else begin
        job.seg[k].mode = MODE_MID;
      end
    end
  end

endmodule

// ===== design/cptxz_back.sv =====
module cptxz_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            valid,
  input  cptxz_pkg::job_t                 job,
  output logic                            pop,
  output logic                            done,
  output logic signed [cptxz_pkg::CW-1:0] near_x,
  output logic signed [cptxz_pkg::CW-1:0] near_y,
  output logic signed [cptxz_pkg::CW-1:0] near_z,
  output logic [1:0]                      region
);
  import cptxz_pkg::*;

  localparam int NDIV = 10;
  localparam int NMUL = 11;
  localparam int SQ   = 4 + QW;

  typedef struct packed {
    vec_t            p;
    vec_t            a;
    vec_t            b;
    vec_t            c;
    logic            interior;
    logic [2:0][1:0] mode;
    logic [NDIV-1:0] neg;
  } side_t;

  function automatic logic signed [CW-1:0] coord(vec_t v, logic [1:0] idx);
    logic signed [CW-1:0] r;
    unique case (idx)
      2'd0:    r = v.x;
      2'd1:    r = v.y;
      default: r = v.z;
    endcase
    return r;
  endfunction

  function automatic vec_t vtx(side_t s, logic [1:0] idx);
    vec_t r;
    unique case (idx)
      2'd0:    r = s.a;
      2'd1:    r = s.b;
      default: r = s.c;
    endcase
    return r;
  endfunction

  job_t                 j0;
  side_t                sd [SQ+1];
  side_t                sd4_next;
  logic [SQ:0]          vp;

  logic signed [PW-1:0] ma [NMUL];
  logic signed [DW-1:0] mb [NMUL];
  logic signed [MW-1:0] mp [NMUL];

  logic [PW-1:0]        dvs0 [NDIV];
  logic [PW-1:0]        dvs1 [NDIV];
  logic [PW-1:0]        dvs2 [NDIV];
  logic [PW-1:0]        dvs3 [NDIV];
  logic [PW-1:0]        dvs4 [NDIV];
  logic signed [NW-1:0] num3 [NDIV];
  logic [NW-1:0]        mag4_q [NDIV];
  logic [NDIV-1:0]      neg_next;
  logic [QW-1:0]        quo [NDIV];

  vec_t                 sa0, ee0;
  logic signed [CW-1:0] cand_next [3][3];
  logic signed [CW-1:0] iy_next;

  logic signed [CW-1:0] cand5 [3][3];
  logic signed [CW-1:0] iy5, px5, pz5;
  logic                 in5, v5;

  logic signed [DW-1:0] ddx [3];
  logic signed [DW-1:0] ddz [3];
  logic signed [PW-1:0] sqx6 [3];
  logic signed [PW-1:0] sqz6 [3];
  logic signed [CW-1:0] cand6 [3][3];
  logic signed [CW-1:0] iy6, px6, pz6;
  logic                 in6, v6;

  logic signed [PW-1:0] dist7 [3];
  logic signed [CW-1:0] cand7 [3][3];
  logic signed [CW-1:0] iy7, px7, pz7;
  logic                 in7, v7;

  logic [1:0]           best;
  logic signed [PW-1:0] bd;

  assign pop = valid;

  always_comb begin
    ma[0] = j0.nv;
    mb[0] = DW'($signed(j0.b.y)) - DW'($signed(j0.a.y));
    ma[1] = j0.nw;
    mb[1] = DW'($signed(j0.c.y)) - DW'($signed(j0.a.y));
    dvs0[0] = j0.den;
    for (int k = 0; k < 3; k++) begin
      unique case (k)
        0: begin sa0 = j0.a; ee0 = j0.b; end
        1: begin sa0 = j0.b; ee0 = j0.c; end
        default: begin sa0 = j0.c; ee0 = j0.a; end
      endcase
      for (int c = 0; c < 3; c++) begin
        ma[2+3*k+c]   = j0.seg[k].dot;
        mb[2+3*k+c]   = DW'(coord(ee0, 2'(c))) - DW'(coord(sa0, 2'(c)));
        dvs0[1+3*k+c] = j0.seg[k].len2;
      end
    end
  end

  for (genvar g = 0; g < NMUL; g++) begin : g_mul
    cptxz_wmul u_mul (
      .clk (clk),
      .a   (ma[g]),
      .b   (mb[g]),
      .p   (mp[g])
    );
  end

  always_comb begin
    for (int i = 0; i < NDIV; i++) begin
      neg_next[i] = num3[i][NW-1];
    end
    sd4_next     = sd[3];
    sd4_next.neg = neg_next;
  end

  for (genvar g = 0; g < NDIV; g++) begin : g_div
    cptxz_div u_div (
      .clk (clk),
      .x0  (mag4_q[g]),
      .dvs (dvs4[g]),
      .quo (quo[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= '0;
    end else begin
      vp <= {vp[SQ-1:0], valid};
    end
  end

  always_ff @(posedge clk) begin
    j0 <= job;
    sd[0].p        <= job.p;
    sd[0].a        <= job.a;
    sd[0].b        <= job.b;
    sd[0].c        <= job.c;
    sd[0].interior <= job.interior;
    sd[0].neg      <= '0;
    for (int k = 0; k < 3; k++) begin
      sd[0].mode[k] <= job.seg[k].mode;
    end
    for (int i = 1; i <= SQ; i++) begin
      if (i == 4) begin
        sd[i] <= sd4_next;
      end else begin
        sd[i] <= sd[i-1];
      end
    end

    for (int i = 0; i < NDIV; i++) begin
      dvs1[i] <= dvs0[i];
      dvs2[i] <= dvs1[i];
      dvs3[i] <= dvs2[i];
      dvs4[i] <= dvs3[i];
      if (i == 0) begin
        num3[i] <= NW'(mp[0]) + NW'(mp[1]);
      end else begin
        num3[i] <= NW'(mp[i+1]);
      end
      mag4_q[i] <= num3[i][NW-1] ? (NW'(dvs3[i]) + ~num3[i]) : num3[i];
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int c = 0; c < 3; c++) begin
        logic signed [CW-1:0] s;
        logic signed [CW-1:0] e;
        logic signed [CW-1:0] q;
        s = coord(vtx(sd[SQ], 2'(k)), 2'(c));
        e = coord(vtx(sd[SQ], (k == 2) ? 2'd0 : 2'(k + 1)), 2'(c));
        q = CW'(quo[1+3*k+c]);
        unique case (sd[SQ].mode[k])
          MODE_START: cand_next[k][c] = s;
          MODE_END:   cand_next[k][c] = e;
          default:    cand_next[k][c] = sd[SQ].neg[1+3*k+c] ? (s - q) : (s + q);
        endcase
      end
    end
    iy_next = sd[SQ].neg[0] ? (sd[SQ].a.y - CW'(quo[0])) : (sd[SQ].a.y + CW'(quo[0]));
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ddx[k] = DW'($signed(px5)) - DW'($signed(cand5[k][0]));
      ddz[k] = DW'($signed(pz5)) - DW'($signed(cand5[k][2]));
    end
  end

  always_comb begin
    best = REGION_AB;
    bd   = dist7[0];
    if (dist7[1] < bd) begin
      best = REGION_BC;
      bd   = dist7[1];
    end
    if (dist7[2] < bd) begin
      best = REGION_CA;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5   <= 1'b0;
      v6   <= 1'b0;
      v7   <= 1'b0;
      done <= 1'b0;
    end else begin
      v5   <= vp[SQ];
      v6   <= v5;
      v7   <= v6;
      done <= v7;
    end
  end

  always_ff @(posedge clk) begin
    cand5 <= cand_next;
    iy5   <= iy_next;
    px5   <= sd[SQ].p.x;
    pz5   <= sd[SQ].p.z;
    in5   <= sd[SQ].interior;

    for (int k = 0; k < 3; k++) begin
      sqx6[k] <= ddx[k] * ddx[k];
      sqz6[k] <= ddz[k] * ddz[k];
    end
    cand6 <= cand5;
    iy6   <= iy5;
    px6   <= px5;
    pz6   <= pz5;
    in6   <= in5;

    for (int k = 0; k < 3; k++) begin
      dist7[k] <= sqx6[k] + sqz6[k];
    end
    cand7 <= cand6;
    iy7   <= iy6;
    px7   <= px6;
    pz7   <= pz6;
    in7   <= in6;

    if (in7) begin
      near_x <= px7;
      near_y <= iy7;
      near_z <= pz7;
      region <= REGION_INSIDE;
    end else begin
      near_x <= cand7[best - 2'd1][0];
      near_y <= cand7[best - 2'd1][1];
      near_z <= cand7[best - 2'd1][2];
      region <= best;
    end
  end

endmodule

// ===== design/closest_point_triangle_xz.sv =====
// Channel   Direction  Handshake                     Payload
// command   in         start, busy (transfer: start & !busy)  point_*, vert_a_*, vert_b_*, vert_c_*
// result    out        done (one cycle, no stall)    near_x, near_y, near_z, region
//
// One item per cycle sustained while busy is low; a command passes the front pipeline,
// the queue and the back pipeline, whose 34-step pipelined restoring dividers make up
// most of its depth, before done rises with the result.
// Reset clears the pipeline valids and the queue; no clearing pass is needed.
// busy rises only when the queue between front and back is full; the back part
// drains one entry every cycle, so results leave on done and cannot be held off.
module closest_point_triangle_xz (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [cptxz_pkg::CW-1:0] point_x,
  input  logic signed [cptxz_pkg::CW-1:0] point_y,
  input  logic signed [cptxz_pkg::CW-1:0] point_z,
  input  logic signed [cptxz_pkg::CW-1:0] vert_a_x,
  input  logic signed [cptxz_pkg::CW-1:0] vert_a_y,
  input  logic signed [cptxz_pkg::CW-1:0] vert_a_z,
  input  logic signed [cptxz_pkg::CW-1:0] vert_b_x,
  input  logic signed [cptxz_pkg::CW-1:0] vert_b_y,
  input  logic signed [cptxz_pkg::CW-1:0] vert_b_z,
  input  logic signed [cptxz_pkg::CW-1:0] vert_c_x,
  input  logic signed [cptxz_pkg::CW-1:0] vert_c_y,
  input  logic signed [cptxz_pkg::CW-1:0] vert_c_z,
  output logic                            done,
  output logic signed [cptxz_pkg::CW-1:0] near_x,
  output logic signed [cptxz_pkg::CW-1:0] near_y,
  output logic signed [cptxz_pkg::CW-1:0] near_z,
  output logic [1:0]                      region
);
  import cptxz_pkg::*;

  vec_t p, a, b, c;
  job_t wjob, rjob;
  logic push, full, qvalid, pop;

  assign p = '{x: point_x, y: point_y, z: point_z};
  assign a = '{x: vert_a_x, y: vert_a_y, z: vert_a_z};
  assign b = '{x: vert_b_x, y: vert_b_y, z: vert_b_z};
  assign c = '{x: vert_c_x, y: vert_c_y, z: vert_c_z};

  cptxz_front u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .p     (p),
    .a     (a),
    .b     (b),
    .c     (c),
    .full  (full),
    .busy  (busy),
    .push  (push),
    .job   (wjob)
  );

  cptxz_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (wjob),
    .pop   (pop),
    .valid (qvalid),
    .rdata (rjob),
    .full  (full)
  );

  cptxz_back u_back (
    .clk    (clk),
    .rst    (rst),
    .valid  (qvalid),
    .job    (rjob),
    .pop    (pop),
    .done   (done),
    .near_x (near_x),
    .near_y (near_y),
    .near_z (near_z),
    .region (region)
  );

endmodule
